// ----- rtl/w36cu_pkg.sv -----
// Shared types and constants of the 36-bit word character unpacker.
package w36cu_pkg;

  // Characters per word in each mode
  localparam int TXT_CHARS = 5;
  localparam int BIN_CHARS = 4;

  // Special characters
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // Input item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_BYTE_MODE = 1'b0;
  localparam logic CFG_KEEP_CR   = 1'b1;

  // Work classes handed from front to back
  localparam logic [1:0] CLS_DATA = 2'd0;
  localparam logic [1:0] CLS_BAD  = 2'd1;
  localparam logic [1:0] CLS_EOF  = 2'd2;

  // Input item as it arrives on the word channel
  typedef struct packed {
    logic        kind;
    logic [39:0] tape_bytes;
    logic [2:0]  char_count;
  } in_item_t;

  // Result item on the character channel
  typedef struct packed {
    logic [7:0] out_char;
    logic       bad_word;
    logic       last;
  } out_item_t;

  // Classified work entry; chars[0] is the first character of the word
  typedef struct packed {
    logic [1:0]                  cls;
    logic                        bmode;
    logic [2:0]                  cnt;
    logic [TXT_CHARS-1:0][7:0]   chars;
  } work_t;

endpackage

// ----- rtl/w36cu_front.sv -----
// Front end: classifies a tape word and splits it into characters.
module w36cu_front (
  input  logic                 byte_mode,
  input  w36cu_pkg::in_item_t  item,
  output w36cu_pkg::work_t     work
);

  logic [35:0] word;
  logic [2:0]  max_cnt;

  // Rebuild the 36-bit word: four full bytes plus the low nibble of the fifth
  assign word    = {item.tape_bytes[39:8], item.tape_bytes[3:0]};
  assign max_cnt = byte_mode ? 3'(w36cu_pkg::BIN_CHARS) : 3'(w36cu_pkg::TXT_CHARS);

  // Classify and extract characters from the most significant end
  always_comb begin
    work.bmode = byte_mode;
    work.cnt   = (item.char_count > max_cnt) ? max_cnt : item.char_count;
    priority if (item.kind == w36cu_pkg::KIND_EOF) begin
      work.cls = w36cu_pkg::CLS_EOF;
    end else if (item.tape_bytes[7:4] != 4'd0) begin
      work.cls = w36cu_pkg::CLS_BAD;
    end else begin
      work.cls = w36cu_pkg::CLS_DATA;
    end
    for (int i = 0; i < w36cu_pkg::TXT_CHARS; i++) begin
      if (byte_mode) begin
        if (i < w36cu_pkg::BIN_CHARS) begin
          work.chars[i] = word[28-8*i +: 8];
        end else begin
          work.chars[i] = 8'd0;
        end
      end else begin
        work.chars[i] = {1'b0, word[29-7*i +: 7]};
      end
    end
  end

endmodule

// ----- rtl/w36cu_queue.sv -----
// Two-entry queue between front and back end.
module w36cu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_stall,
  input  w36cu_pkg::work_t  push_data,
  output logic              pop_valid,
  input  logic              pop,
  output w36cu_pkg::work_t  head
);

  w36cu_pkg::work_t mem [2];
  logic [1:0]       used;
  logic             wptr;
  logic             rptr;
  logic             push;

  assign push_stall = (used == 2'd2);
  assign push       = push_valid && !push_stall;
  assign pop_valid  = (used != 2'd0);
  assign head       = mem[rptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// ----- rtl/w36cu_back.sv -----
// Back end: steps through a work entry, applies CR handling, drives results.
module w36cu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 keep_cr,
  input  logic                 q_valid,
  input  w36cu_pkg::work_t     head,
  output logic                 pop,
  output logic                 char_valid,
  input  logic                 char_stall,
  output w36cu_pkg::out_item_t char_data
);

  logic [2:0] idx;
  logic       pend;
  logic       hold_v;
  logic [7:0] hold_c;
  logic       hold_bad;
  logic       ov;
  w36cu_pkg::out_item_t od;

  logic       out_free;
  logic       en;
  logic [7:0] c;
  logic       prod;
  logic [7:0] r_c;
  logic       r_bad;
  logic       adv;
  logic       fin;
  logic       pend_next;
  logic       send;

  assign out_free   = !ov || !char_stall;
  assign en         = out_free && q_valid;
  assign c          = head.chars[idx];
  assign char_valid = ov;
  assign char_data  = od;

  // One step of the current entry: at most one result
  always_comb begin
    prod      = 1'b0;
    r_c       = 8'd0;
    r_bad     = 1'b0;
    adv       = 1'b0;
    fin       = 1'b0;
    pend_next = pend;
    unique case (head.cls)
      w36cu_pkg::CLS_EOF: begin
        prod      = pend;
        r_c       = w36cu_pkg::CH_CR;
        fin       = 1'b1;
        pend_next = 1'b0;
      end
      w36cu_pkg::CLS_BAD: begin
        prod  = 1'b1;
        r_bad = 1'b1;
        fin   = 1'b1;
      end
      w36cu_pkg::CLS_DATA: begin
        priority if (idx >= head.cnt) begin
          fin = 1'b1;
        end else if (head.bmode) begin
          prod = 1'b1;
          r_c  = c;
          adv  = 1'b1;
          fin  = (idx + 3'd1 == head.cnt);
        end else if (pend && c != w36cu_pkg::CH_LF) begin
          // held CR goes out before this character
          prod      = 1'b1;
          r_c       = w36cu_pkg::CH_CR;
          pend_next = 1'b0;
        end else begin
          prod      = (c != w36cu_pkg::CH_CR) || keep_cr;
          r_c       = c;
          pend_next = !keep_cr && (c == w36cu_pkg::CH_CR);
          adv       = 1'b1;
          fin       = (idx + 3'd1 == head.cnt);
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // Entry is done unless a fresh result still sits behind a held one
  assign pop = en && fin && !(hold_v && prod);

  // A result moves to the output register this cycle
  assign send = en && (hold_v ? (prod || fin) : (prod && fin));

  // Step state, held result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= 3'd0;
      pend   <= 1'b0;
      hold_v <= 1'b0;
      ov     <= 1'b0;
    end else begin
      if (send) begin
        ov <= 1'b1;
      end else if (out_free) begin
        ov <= 1'b0;
      end
      if (en) begin
        pend <= pend_next;
        if (pop) begin
          idx <= 3'd0;
        end else if (adv) begin
          idx <= idx + 3'd1;
        end
        if (hold_v) begin
          if (!prod && fin) begin
            hold_v <= 1'b0;
          end
        end else if (prod && !fin) begin
          hold_v <= 1'b1;
        end
      end
    end
  end

  // Payload side of the above
  always_ff @(posedge clk) begin
    if (en) begin
      if (hold_v && (prod || fin)) begin
        od.out_char <= hold_c;
        od.bad_word <= hold_bad;
        od.last     <= !prod;
      end else if (!hold_v && prod && fin) begin
        od.out_char <= r_c;
        od.bad_word <= r_bad;
        od.last     <= 1'b1;
      end
      if (prod) begin
        hold_c   <= r_c;
        hold_bad <= r_bad;
      end
    end
  end

  // A held result only ever belongs to a data entry still in the queue
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    hold_v |-> (q_valid && head.cls == w36cu_pkg::CLS_DATA))
    else $error("held result without a data entry");

  // Character position never runs past the entry's count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (idx <= head.cnt))
    else $error("character index past count");

  // A bad word result is always the only, hence last, result of its item
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    (ov && od.bad_word) |-> od.last)
    else $error("bad word result not marked last");

  // Popping an entry leaves nothing held back
  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    pop |=> !hold_v)
    else $error("result left behind after entry finished");

endmodule

// ----- rtl/word36_char_unpacker_top.sv -----
// Top level of the 36-bit tape word character unpacker.
// Word channel (word_valid/word_stall/word_data): one tape word or an
// end-of-file marker per item. Character channel (char_valid/char_stall/
// char_data): one character or byte per item, last set on the final result
// of each input item; a word with a bad fifth byte gives a single result
// with bad_word set. Configuration: cfg_we writes cfg_data to register
// cfg_index (0 byte_mode, 1 keep_cr); write only while the block is idle.
// A result whose step also finishes its input item, with nothing held,
// goes straight to the output register; any other result waits in the hold
// register until a later step shows whether it is the last. The back end
// spends one cycle per result and per dropped CR while the output is free
// and the queue holds an entry, plus a closing step on words whose last
// result was held back. The two-entry queue lets words be taken while
// results are still going out. Reset clears the queue, the output
// register, the held CR and both configuration registers. When the
// receiver stalls the output result holds, the back end stops and the
// queue fills, after which word_stall rises.
module word36_char_unpacker_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 word_valid,
  output logic                 word_stall,
  input  w36cu_pkg::in_item_t  word_data,
  output logic                 char_valid,
  input  logic                 char_stall,
  output w36cu_pkg::out_item_t char_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_data
);

  logic             byte_mode;
  logic             keep_cr;
  w36cu_pkg::work_t work;
  w36cu_pkg::work_t head;
  logic             q_valid;
  logic             pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_mode <= 1'b0;
      keep_cr   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        w36cu_pkg::CFG_BYTE_MODE: byte_mode <= cfg_data;
        w36cu_pkg::CFG_KEEP_CR:   keep_cr   <= cfg_data;
        default:                  byte_mode <= byte_mode;
      endcase
    end
  end

  w36cu_front u_front (
    .byte_mode (byte_mode),
    .item      (word_data),
    .work      (work)
  );

  w36cu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (word_valid),
    .push_stall (word_stall),
    .push_data  (work),
    .pop_valid  (q_valid),
    .pop        (pop),
    .head       (head)
  );

  w36cu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .keep_cr    (keep_cr),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the 36-bit tape word character unpacker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] CR7 = 7'(w36cu_pkg::CH_CR);
  localparam logic [6:0] LF7 = 7'(w36cu_pkg::CH_LF);
  localparam int SETTLE_CYCLES = 30;   // drain time after the last expected char
  localparam int STUCK_LIMIT   = 2000; // cycles with no transfer before giving up
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 word_valid = 1'b0;
  logic                 word_stall;
  w36cu_pkg::in_item_t  word_data = '0;
  logic                 char_valid;
  logic                 char_stall = 1'b0;
  w36cu_pkg::out_item_t char_data;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = w36cu_pkg::CFG_BYTE_MODE;
  logic                 cfg_data = 1'b0;

  // Items waiting to be offered and characters waiting to arrive
  w36cu_pkg::in_item_t  word_q[$];
  w36cu_pkg::out_item_t expected_chars[$];

  // Predictor state and configuration
  logic mode_bytes = 1'b0;
  logic cr_kept = 1'b0;
  logic cr_held = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int mismatches = 0;
  int words_taken = 0;
  int eofs_taken = 0;
  int chars_checked = 0;
  int bad_checked = 0;

  word36_char_unpacker_top dut (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word_data  (word_data),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic w36cu_pkg::out_item_t char_res(logic [7:0] ch, logic bad);
    w36cu_pkg::out_item_t r;
    r.out_char = ch;
    r.bad_word = bad;
    r.last     = 1'b0;
    return r;
  endfunction

  // Work out the characters one accepted item gives and queue them
  function automatic void unpack_word(w36cu_pkg::in_item_t it);
    w36cu_pkg::out_item_t res[$];
    logic [35:0]          wd;
    logic [6:0]           c;
    int                   n;
    if (it.kind == w36cu_pkg::KIND_EOF) begin
      if (cr_held) res.push_back(char_res(w36cu_pkg::CH_CR, 1'b0));
      cr_held = 1'b0;
    end else if (it.tape_bytes[7:4] != 4'h0) begin
      res.push_back(char_res(8'h00, 1'b1));
    end else begin
      wd = {it.tape_bytes[39:8], it.tape_bytes[3:0]};
      n  = it.char_count;
      if (mode_bytes) begin
        if (n > w36cu_pkg::BIN_CHARS) n = w36cu_pkg::BIN_CHARS;
        for (int i = 0; i < n; i++)
          res.push_back(char_res(8'(wd >> (28 - 8 * i)), 1'b0));
      end else begin
        if (n > w36cu_pkg::TXT_CHARS) n = w36cu_pkg::TXT_CHARS;
        for (int i = 0; i < n; i++) begin
          c = 7'(wd >> (29 - 7 * i));
          // a held CR goes out unless an LF follows it
          if (cr_held && c != LF7) res.push_back(char_res(w36cu_pkg::CH_CR, 1'b0));
          if (c != CR7 || cr_kept) res.push_back(char_res({1'b0, c}, 1'b0));
          cr_held = !cr_kept && c == CR7;
        end
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[k]) expected_chars.push_back(res[k]);
  endfunction

  // Tape bytes of a word holding five 7-bit characters, spare bit low
  function automatic logic [39:0] text_tape(logic [6:0] c0, logic [6:0] c1, logic [6:0] c2,
                                            logic [6:0] c3, logic [6:0] c4);
    logic [35:0] wd;
    wd = {c0, c1, c2, c3, c4, 1'b0};
    return {wd[35:4], 4'h0, wd[3:0]};
  endfunction

  function automatic logic [6:0] rand_char();
    int r;
    r = $urandom_range(9);
    if (r < 2) return CR7;
    if (r < 4) return LF7;
    if (r == 4) return ($urandom_range(1) != 0) ? 7'h7F : 7'h00;
    return 7'($urandom);
  endfunction

  // Mostly well-formed text words, plus markers, bad words and raw noise
  function automatic w36cu_pkg::in_item_t rand_item();
    w36cu_pkg::in_item_t it;
    int                  r;
    r = $urandom_range(99);
    it.kind       = w36cu_pkg::KIND_DATA;
    it.char_count = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5, 1));
    if (r < 8) begin
      it.kind       = w36cu_pkg::KIND_EOF;
      it.tape_bytes = 40'({$urandom, $urandom});
      it.char_count = 3'($urandom);
    end else if (r < 16) begin
      it.tape_bytes      = 40'({$urandom, $urandom});
      it.tape_bytes[7:4] = 4'($urandom_range(15, 1));
    end else if (r < 30) begin
      it.tape_bytes      = 40'({$urandom, $urandom});
      it.tape_bytes[7:4] = 4'h0;
    end else begin
      it.tape_bytes    = text_tape(rand_char(), rand_char(), rand_char(), rand_char(),
                                   rand_char());
      it.tape_bytes[0] = 1'($urandom);
    end
    return it;
  endfunction

  task automatic push_word(logic kind, logic [39:0] tb, logic [2:0] cnt);
    w36cu_pkg::in_item_t it;
    it.kind       = kind;
    it.tape_bytes = tb;
    it.char_count = cnt;
    word_q.push_back(it);
  endtask

  task automatic push_random(int count);
    repeat (count) word_q.push_back(rand_item());
  endtask

  // Both registers are written back to back while the block is idle
  task automatic set_config(logic bmode, logic keep);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= w36cu_pkg::CFG_BYTE_MODE;
    cfg_data  <= bmode;
    @(posedge clk);
    cfg_index <= w36cu_pkg::CFG_KEEP_CR;
    cfg_data  <= keep;
    @(posedge clk);
    cfg_we     <= 1'b0;
    mode_bytes  = bmode;
    cr_kept     = keep;
    @(negedge clk);
  endtask

  // Wait until every item has gone in and every char has come out
  task automatic wait_idle();
    @(negedge clk);
    while (word_q.size() > 0 || word_valid || expected_chars.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Word channel driver: prediction happens at the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else begin
      if (word_valid && !word_stall) begin
        unpack_word(word_data);
        if (word_data.kind == w36cu_pkg::KIND_EOF) eofs_taken++;
        else words_taken++;
      end
      if (!word_valid || !word_stall) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          word_valid <= 1'b1;
          word_data  <= word_q.pop_front();
        end else begin
          word_valid <= 1'b0;
        end
      end
    end
  end

  // Character channel monitor and receiver stalls
  always @(posedge clk) begin
    w36cu_pkg::out_item_t want;
    if (rst) begin
      char_stall <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        if (expected_chars.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected char: char %h bad %b last %b", char_data.out_char,
                     char_data.bad_word, char_data.last);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (char_data.bad_word) bad_checked++;
          else chars_checked++;
          if (char_data.out_char !== want.out_char || char_data.bad_word !== want.bad_word ||
              char_data.last !== want.last) begin
            if (mismatches < 10)
              $display("mismatch: expected char %h bad %b last %b, got char %h bad %b last %b",
                       want.out_char, want.bad_word, want.last, char_data.out_char,
                       char_data.bad_word, char_data.last);
            mismatches++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        char_stall <= 1'b1;
      end else begin
        char_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((word_valid && !word_stall) || (char_valid && !char_stall)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Text mode, CR stripped, no idling on either side
    set_config(1'b0, 1'b0);
    push_word(w36cu_pkg::KIND_DATA, 40'h00_0000_0000, 3'd5);
    push_word(w36cu_pkg::KIND_DATA, 40'hFF_FFFF_FF0F, 3'd5);
    push_word(w36cu_pkg::KIND_DATA, 40'hFF_FFFF_FF0F, 3'd0);
    push_word(w36cu_pkg::KIND_DATA, text_tape(7'h61, 7'h62, 7'h63, 7'h64, 7'h65), 3'd7);
    push_word(w36cu_pkg::KIND_DATA, text_tape(7'h7F, 7'h00, 7'h7F, 7'h00, 7'h7F), 3'd6);
    push_word(w36cu_pkg::KIND_DATA, 40'hFF_FFFF_FFFF, 3'd5);
    push_word(w36cu_pkg::KIND_DATA, 40'h00_0000_0010, 3'd3);
    // CRLF inside a word, CR left held at the end
    push_word(w36cu_pkg::KIND_DATA, text_tape(7'h41, CR7, LF7, 7'h42, CR7), 3'd5);
    // held CR released before a plain char, CR runs
    push_word(w36cu_pkg::KIND_DATA, text_tape(7'h43, CR7, 7'h44, CR7, CR7), 3'd5);
    // bad word leaves the held CR alone
    push_word(w36cu_pkg::KIND_DATA, 40'h12_3456_7880, 3'd5);
    // LF at the start of the next word swallows the held CR
    push_word(w36cu_pkg::KIND_DATA, text_tape(LF7, 7'h30, 7'h31, 7'h32, 7'h33), 3'd1);
    push_word(w36cu_pkg::KIND_DATA, text_tape(CR7, 7'h00, 7'h00, 7'h00, 7'h00), 3'd1);
    push_word(w36cu_pkg::KIND_EOF, 40'h00_0000_0000, 3'd0);
    push_word(w36cu_pkg::KIND_EOF, 40'hFF_FFFF_FFFF, 3'd7);
    push_word(w36cu_pkg::KIND_DATA, text_tape(CR7, 7'h00, 7'h00, 7'h00, 7'h00), 3'd1);
    push_word(w36cu_pkg::KIND_EOF, 40'h5A_A5C3_3C96, 3'd5);
    push_random(120);
    // leave a CR held for the next setting
    push_word(w36cu_pkg::KIND_DATA, text_tape(7'h65, CR7, 7'h00, 7'h00, 7'h00), 3'd2);
    wait_idle();

    // Text mode, CR kept, with a long receiver hold-off
    send_idle_pct = 22;
    recv_idle_pct = 22;
    set_config(1'b0, 1'b1);
    push_word(w36cu_pkg::KIND_DATA, text_tape(LF7, 7'h78, CR7, LF7, 7'h79), 3'd5);
    push_random(100);
    hold_req = 1'b1;
    wait_idle();

    // Text mode, CR stripped again, ending with a CR held
    set_config(1'b0, 1'b0);
    push_random(60);
    push_word(w36cu_pkg::KIND_DATA, text_tape(7'h71, CR7, 7'h00, 7'h00, 7'h00), 3'd2);
    wait_idle();

    // Byte mode, CR kept: bytes pass through, held CR untouched
    set_config(1'b1, 1'b1);
    push_word(w36cu_pkg::KIND_DATA, 40'h0D_0D0D_0D0D, 3'd5);
    push_word(w36cu_pkg::KIND_DATA, 40'hFF_FFFF_FF0F, 3'd7);
    push_word(w36cu_pkg::KIND_DATA, 40'h12_3456_7809, 3'd3);
    push_word(w36cu_pkg::KIND_DATA, 40'hA5_5AA5_5A0A, 3'd0);
    push_word(w36cu_pkg::KIND_DATA, 40'h00_0000_00F0, 3'd4);
    wait_idle();

    // Text mode, CR kept, held CR from earlier goes out before a plain char
    set_config(1'b0, 1'b1);
    push_word(w36cu_pkg::KIND_DATA, text_tape(7'h5A, CR7, LF7, 7'h00, 7'h00), 3'd3);
    push_random(60);
    wait_idle();

    // Byte mode, CR stripped
    set_config(1'b1, 1'b0);
    push_random(110);
    wait_idle();

    if (expected_chars.size() > 0) begin
      $display("%0d expected chars never arrived", expected_chars.size());
      mismatches++;
    end
    $display("covered %0d data words and %0d end-of-file markers over six configuration phases;",
             words_taken, eofs_taken);
    $display("checked %0d chars and %0d bad-word results, %0d mismatches", chars_checked,
             bad_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
